// ===== rtl/ffba_pkg.sv =====
// ---------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ---------------------------------------------------------------------------
package ffba_pkg;

    // Port field widths
    localparam int IDX_PORT_W  = 4;
    localparam int SIZE_PORT_W = 16;
    localparam int TOTAL_W     = 20;
    localparam int BIU_W       = 5;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;

    // req_type codes on s_tuser
    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_ALLOC = 1'b1
    } req_kind_t;

    // Classified operation handed to the back end
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_DROP  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [IDX_PORT_W-1:0]  index;
        logic [SIZE_PORT_W-1:0] size;
    } req_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_COMMIT = 1'b1
    } back_state_t;

endpackage

// ===== rtl/ffba_front.sv =====
// ---------------------------------------------------------------------------
// ffba_front
// Accepts requests, classifies them and pushes them into the queue.
// ---------------------------------------------------------------------------
module ffba_front #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ffba_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    input  logic                              queue_full,
    output logic                              push,
    output ffba_pkg::req_t                    push_data
);
    import ffba_pkg::*;

    localparam logic [SIZE_PORT_W-1:0] SZ_MASK =
        (SIZE_BITS >= SIZE_PORT_W) ? {SIZE_PORT_W{1'b1}}
                                   : SIZE_PORT_W'((64'd1 << SIZE_BITS) - 64'd1);

    logic [IDX_PORT_W-1:0]  in_index;
    logic [SIZE_PORT_W-1:0] in_size;

    assign in_index = s_tdata[IDX_PORT_W-1:0];
    assign in_size  = s_tdata[IDX_PORT_W +: SIZE_PORT_W] & SZ_MASK;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        push_data.index = in_index;
        push_data.size  = in_size;
        unique case (s_tuser)
            REQ_LOAD: begin
                // loads beyond the table are dropped but still answered
                push_data.op = (int'(in_index) < NUM_BLOCKS) ? OP_LOAD : OP_DROP;
            end
            REQ_ALLOC: begin
                push_data.op = OP_ALLOC;
            end
        endcase
    end

endmodule

// ===== rtl/ffba_queue.sv =====
// ---------------------------------------------------------------------------
// ffba_queue
// Short FIFO of classified requests between front and back end.
// ---------------------------------------------------------------------------
module ffba_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ffba_pkg::req_t push_data,
    input  logic           pop,
    output ffba_pkg::req_t head,
    output logic           head_valid,
    output logic           full
);
    import ffba_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    req_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/ffba_back.sv =====
// ---------------------------------------------------------------------------
// ffba_back
// Free-space table, first-fit search and result register.
// ---------------------------------------------------------------------------
module ffba_back #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [ffba_pkg::BIU_W-1:0]        biu,
    input  ffba_pkg::req_t                    head,
    input  logic                              head_valid,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic                              res_granted,
    output logic [ffba_pkg::IDX_PORT_W-1:0]   res_block,
    output logic [ffba_pkg::TOTAL_W-1:0]      res_total
);
    import ffba_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    back_state_t            state_reg, state_next;
    logic [SIZE_BITS-1:0]   free_reg [NUM_BLOCKS];
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   out_valid_reg, out_valid_next;
    req_t                   req_reg;
    logic [NUM_BLOCKS-1:0]  hit_reg;
    logic [NUM_BLOCKS-1:0]  hit_now;
    logic                   granted_reg;
    logic [IDX_PORT_W-1:0]  block_reg;

    logic                   out_free;
    logic                   commit;
    logic                   found;
    logic [IDX_W-1:0]       sel;
    logic [IDX_W-1:0]       load_idx;
    logic [SIZE_BITS-1:0]   req_size;
    logic [SIZE_BITS-1:0]   head_size;
    logic [NUM_BLOCKS-1:0]  wr_lane;
    logic                   cm_granted;
    logic [IDX_PORT_W-1:0]  cm_block;

    assign out_free  = !out_valid_reg || m_tready;
    assign head_size = SIZE_BITS'(head.size);
    assign req_size  = SIZE_BITS'(req_reg.size);
    assign load_idx  = IDX_W'(req_reg.index);

    // fit compare per lane, against the queue head
    always_comb begin
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            hit_now[i] = (free_reg[i] >= head_size) && (i < int'(biu));
        end
    end

    // lowest fitting lane wins
    always_comb begin
        found = |hit_reg;
        sel   = '0;
        for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
            if (hit_reg[i]) begin
                sel = IDX_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (head_valid) state_next = ST_COMMIT;
            ST_COMMIT: if (out_free)   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop    = 1'b0;
        commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:   pop    = head_valid;
            ST_COMMIT: commit = out_free;
        endcase
    end

    // commit decode
    always_comb begin
        wr_lane    = '0;
        total_next = total_reg;
        cm_granted = 1'b0;
        cm_block   = '0;
        unique case (req_reg.op)
            OP_LOAD: begin
                wr_lane[load_idx] = 1'b1;
                total_next = total_reg - TOTAL_W'(free_reg[load_idx]) + TOTAL_W'(req_size);
                cm_granted = 1'b1;
                cm_block   = req_reg.index;
            end
            OP_ALLOC: begin
                if (found) begin
                    wr_lane[sel] = 1'b1;
                    total_next = total_reg - TOTAL_W'(req_size);
                    cm_granted = 1'b1;
                    cm_block   = IDX_PORT_W'(sel);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                free_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit) begin
                total_reg <= total_next;
            end
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                if (commit && wr_lane[i]) begin
                    free_reg[i] <= (req_reg.op == OP_LOAD) ? req_size
                                                           : free_reg[i] - req_size;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            req_reg <= head;
            hit_reg <= hit_now;
        end
        if (commit) begin
            granted_reg <= cm_granted;
            block_reg   <= cm_block;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign res_granted = granted_reg;
    assign res_block   = block_reg;
    assign res_total   = total_reg;

endmodule

// ===== rtl/first_fit_block_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit allocator over a table of per-block free sizes.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request per transfer: s_tuser = req_type
//   (0 load, 1 allocate), s_tdata = block_index, request_size.
//   m_ channel returns one result per request, in order: m_tuser = granted,
//   m_tdata = granted_block, remaining_total.
//   cfg_wr_en/cfg_wr_data write blocks_in_use (write only while idle).
// Flow: an accepted request is written into the queue, popped into the
//   back end's request register with its fit compare, then committed to
//   the result register once the output is free. The back end takes the
//   next request only after the previous commit, as its compare-then-commit
//   sequence requires: each search must see the previous request's table update.
// A 2-entry queue decouples the front from the back, so requests are taken
//   while a result waits on m_tready; the back end holds in its commit step
//   while the result register is full, and s_tready drops once the queue
//   fills.
// Reset: all free sizes and the running total clear to zero, the queue
//   empties and blocks_in_use returns to 16. No clearing pass is needed.
// ---------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ffba_pkg::S_TDATA_W-1:0]    s_tdata,   // [3:0] block_index, [19:4] request_size
    input  logic                              s_tuser,   // [0] req_type
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ffba_pkg::M_TDATA_W-1:0]    m_tdata,   // [3:0] granted_block, [23:4] remaining_total
    output logic                              m_tuser,   // [0] granted
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [ffba_pkg::BIU_W-1:0]        cfg_wr_data
);
    import ffba_pkg::*;

    logic [BIU_W-1:0]      biu_reg;
    logic                  q_push;
    req_t                  q_push_data;
    logic                  q_pop;
    req_t                  q_head;
    logic                  q_head_valid;
    logic                  q_full;
    logic                  res_granted;
    logic [IDX_PORT_W-1:0] res_block;
    logic [TOTAL_W-1:0]    res_total;

    // blocks_in_use; values above NUM_BLOCKS simply enable every lane
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            biu_reg <= BIU_RESET;
        end else if (cfg_wr_en) begin
            biu_reg <= cfg_wr_data;
        end
    end

    // front: handshake and classification (load / allocate / dropped load)
    ffba_front #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (q_full),
        .push       (q_push),
        .push_data  (q_push_data)
    );

    // decoupling queue
    ffba_queue #(
        .DEPTH (2)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_data),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid),
        .full       (q_full)
    );

    // back: table lanes, first-fit search, write-back and result register
    ffba_back #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .biu         (biu_reg),
        .head        (q_head),
        .head_valid  (q_head_valid),
        .pop         (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .res_granted (res_granted),
        .res_block   (res_block),
        .res_total   (res_total)
    );

    assign m_tuser = res_granted;
    assign m_tdata = {res_total, res_block};

endmodule

// ===== rtl/ffba_checker.sv =====
// ---------------------------------------------------------------------------
// ffba_checker
// Port-level assertions for the first-fit allocator, bound to the top.
// ---------------------------------------------------------------------------
module ffba_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ffba_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                              m_tuser
);
    import ffba_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no stale result survives reset
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // queue is empty after reset, so requests are taken at once
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("request side not ready after reset");

    // a refused request reports block zero
    a_refused_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[IDX_PORT_W-1:0] == '0)
        else $error("refused request with nonzero block");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
